### design/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet helpers for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

   localparam int unsigned QueueDepth = 2;

   localparam logic ModeEncode = 1'b0;
   localparam logic ModeDecode = 1'b1;

   localparam logic [7:0] CharPad   = 8'h3D;  // '='
   localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
   localparam logic [7:0] CharSlash = 8'h2F;  // '/'

   // one group of results: up to four bytes, first in the top
   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  cnt_m1;
      logic        last;
      logic        bad;
   } b64c_entry_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26)      c = 8'h41 + {2'b00, v};
      else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
      else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
      else if (v == 6'd62) c = CharPlus;
      else                c = CharSlash;
      return c;
   endfunction

   // {ok, sextet}
   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      logic [6:0] r;
      if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
      else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      else if (c == CharPlus)            r = {1'b1, 6'd62};
      else if (c == CharSlash)           r = {1'b1, 6'd63};
      else                               r = 7'd0;
      return r;
   endfunction

endpackage

### design/b64c_req_if.sv
// ----------------------------------------------------------------------------
// b64c_req_if
// Input channel: one byte per beat with an end-of-stream mark.
// ----------------------------------------------------------------------------
interface b64c_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

### design/b64c_rsp_if.sv
// ----------------------------------------------------------------------------
// b64c_rsp_if
// Result channel: one byte per beat with end-of-stream and error marks.
// ----------------------------------------------------------------------------
interface b64c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       bad_input;

   modport source (output valid, output out_byte, output out_last, output bad_input,
                   input ready);
   modport sink (input valid, input out_byte, input out_last, input bad_input,
                 output ready);
endinterface

### design/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input beats, tracks group state and builds one result entry per
// finished group or error.
// ----------------------------------------------------------------------------
module b64c_front (
   input  logic                    clock,
   input  logic                    reset,
   b64c_req_if.sink                req,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    q_full,
   output logic                    q_push,
   output b64c_pkg::b64c_entry_type q_entry
);
   import b64c_pkg::*;

   logic        mode_ff, mode_in;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  pad_ff, pad_in;
   logic        disc_ff, disc_in;

   logic        accept;
   logic [1:0]  pos;
   logic [23:0] merged;
   logic [1:0]  n;
   logic [6:0]  sx;
   logic        err;
   logic        emit;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      mode_in = mode_ff;
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      pad_in  = pad_ff;
      disc_in = disc_ff;
      emit    = 1'b0;
      err     = 1'b0;
      q_entry = '0;
      pos     = cnt_ff;
      merged  = bits_ff;
      n       = 2'd0;
      sx      = char_sextet(req.in_byte);

      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         bits_in = '0;
         cnt_in  = '0;
         pad_in  = '0;
         disc_in = 1'b0;
      end else if (accept && mode_ff == ModeEncode) begin
         if (pos > 2'd2) pos = 2'd2;
         case (pos)
            2'd0:    merged = bits_ff | {req.in_byte, 16'h0000};
            2'd1:    merged = bits_ff | {8'h00, req.in_byte, 8'h00};
            default: merged = bits_ff | {16'h0000, req.in_byte};
         endcase
         n = pos + 2'd1;
         if (n < 2'd3 && !req.in_last) begin
            bits_in = merged;
            cnt_in  = n;
         end else begin
            emit = 1'b1;
            q_entry.data[31:24] = sextet_char(merged[23:18]);
            q_entry.data[23:16] = sextet_char(merged[17:12]);
            q_entry.data[15:8]  = (n >= 2'd2) ? sextet_char(merged[11:6]) : CharPad;
            q_entry.data[7:0]   = (n == 2'd3) ? sextet_char(merged[5:0]) : CharPad;
            q_entry.cnt_m1 = 2'd3;
            q_entry.last   = req.in_last;
            bits_in = '0;
            cnt_in  = '0;
            pad_in  = '0;
         end
      end else if (accept) begin
         if (disc_ff) begin
            if (req.in_last) begin
               disc_in = 1'b0;
               bits_in = '0;
               cnt_in  = '0;
               pad_in  = '0;
            end
         end else begin
            if (req.in_byte == CharPad) begin
               if (pos < 2'd2) err = 1'b1;
               else pad_in = pad_ff + 2'd1;
            end else if (!sx[6] || pad_ff != 2'd0) begin
               err = 1'b1;
            end else begin
               case (pos)
                  2'd0:    merged = bits_ff | {sx[5:0], 18'd0};
                  2'd1:    merged = bits_ff | {6'd0, sx[5:0], 12'd0};
                  2'd2:    merged = bits_ff | {12'd0, sx[5:0], 6'd0};
                  default: merged = bits_ff | {18'd0, sx[5:0]};
               endcase
            end
            if (!err) begin
               if (pos < 2'd3) begin
                  if (req.in_last) err = 1'b1;
                  else begin
                     bits_in = merged;
                     cnt_in  = pos + 2'd1;
                  end
               end else if (pad_in != 2'd0 && !req.in_last) begin
                  err = 1'b1;
               end else begin
                  emit = 1'b1;
                  q_entry.data   = {merged, 8'h00};
                  q_entry.cnt_m1 = 2'd2 - pad_in;
                  q_entry.last   = req.in_last;
                  bits_in = '0;
                  cnt_in  = '0;
                  pad_in  = '0;
               end
            end
            if (err) begin
               emit    = 1'b1;
               q_entry = '0;
               q_entry.last = 1'b1;
               q_entry.bad  = 1'b1;
               bits_in = '0;
               cnt_in  = '0;
               pad_in  = '0;
               disc_in = !req.in_last;
            end
         end
      end
   end

   assign q_push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeEncode;
         bits_ff <= '0;
         cnt_ff  <= '0;
         pad_ff  <= '0;
         disc_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
         pad_ff  <= pad_in;
         disc_ff <= disc_in;
      end
   end

endmodule

### design/b64c_queue.sv
// ----------------------------------------------------------------------------
// b64c_queue
// Small FIFO of result entries between front and back.
// ----------------------------------------------------------------------------
module b64c_queue #(
   parameter int unsigned Depth = b64c_pkg::QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64c_pkg::b64c_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output b64c_pkg::b64c_entry_type head
);
   import b64c_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   b64c_entry_type        slot_ff [Depth];
   logic [PtrW-1:0]       wr_ff, wr_in;
   logic [PtrW-1:0]       rd_ff, rd_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full      = (cnt_ff == CntW'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

### design/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back
// Takes entries from the queue and sends their bytes one beat at a time
// through a registered output stage.
// ----------------------------------------------------------------------------
module b64c_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  b64c_pkg::b64c_entry_type q_head,
   output logic                     q_pop,
   b64c_rsp_if.source               rsp
);
   import b64c_pkg::*;

   b64c_entry_type cur_ff, cur_in;
   logic           cur_valid_ff, cur_valid_in;
   logic [1:0]     idx_ff, idx_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;
   logic           out_bad_ff, out_bad_in;

   logic           take_out;
   logic           at_end;
   logic           cur_free;
   logic [7:0]     sel_byte;

   assign take_out = !out_valid_ff || rsp.ready;
   assign at_end   = (idx_ff == cur_ff.cnt_m1);
   assign cur_free = !cur_valid_ff || (take_out && at_end);
   assign q_pop    = cur_free && q_valid;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = cur_ff.data[31:24];
         2'd1:    sel_byte = cur_ff.data[23:16];
         2'd2:    sel_byte = cur_ff.data[15:8];
         default: sel_byte = cur_ff.data[7:0];
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;

      if (take_out) begin
         out_valid_in = cur_valid_ff;
         if (cur_valid_ff) begin
            out_byte_in = sel_byte;
            out_last_in = at_end && cur_ff.last;
            out_bad_in  = cur_ff.bad;
            idx_in      = idx_ff + 2'd1;
         end
      end
      if (cur_free) begin
         cur_valid_in = q_valid;
         cur_in       = q_head;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_byte  = out_byte_ff;
   assign rsp.out_last  = out_last_ff;
   assign rsp.bad_input = out_bad_ff;

endmodule

### design/base64_stream_codec.sv
// A group's first result beat passes through a queue slot, the current-entry register
// and the output register.
// Throughput: one input beat per cycle while the queue is not full; one result beat
// per cycle while the receiver is ready, so the output stage limits encode but not decode.
// Reset (synchronous): encode mode, empty group, queue and output stage empty.
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 encoder/decoder with a mode register, front classifier, entry queue
// and serializing back end.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
   parameter int unsigned QueueDepth = b64c_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   b64c_req_if.sink   req,
   b64c_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import b64c_pkg::*;

   logic           q_full;
   logic           q_push;
   logic           q_pop;
   logic           q_valid;
   b64c_entry_type q_entry;
   b64c_entry_type q_head;

   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   b64c_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   b64c_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule
